FILE: hw/rtl/vpcu_pkg.sv
// ----------------------------------------------------------------------------
// Vending price and change unit package
// Shared codes, widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vpcu_pkg;

  localparam int PRODUCT_SLOTS_DEF = 64;
  localparam int CODE_W            = 6;
  localparam int CODE_EXT_W        = 9;
  localparam int MONEY_W           = 16;
  localparam int ADD_W             = 8;
  localparam int TENS_W            = 13;
  localparam int FIVES_W           = 14;

  typedef enum logic [2:0] {
    OPC_WRITE   = 3'd0,
    OPC_DELETE  = 3'd1,
    OPC_RESTOCK = 3'd2,
    OPC_BUY     = 3'd3,
    OPC_CHANGE  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CREDIT    = 2'd1,
    ST_NO_CHANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_EXEC,
    MOP_BUY,
    MOP_DIV10,
    MOP_MIN10,
    MOP_SUB10,
    MOP_DIV5,
    MOP_MIN5,
    MOP_SUB5,
    MOP_ONES,
    MOP_COMMIT,
    MOP_OUT
  } mop_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_BUY,
    S_DIV10,
    S_MIN10,
    S_SUB10,
    S_DIV5,
    S_MIN5,
    S_SUB5,
    S_ONES,
    S_COMMIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;
    mop_t mop;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vpcu_ram.sv
// ----------------------------------------------------------------------------
// Vending price and change unit RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpcu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vpcu_ctrl.sv
// ----------------------------------------------------------------------------
// Vending price and change unit controller
// Sequences each transaction through the datapath micro-operations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpcu_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vpcu_pkg::sts_t sts,
  output vpcu_pkg::cmd_t      cmd
);

  vpcu_pkg::state_t state;
  vpcu_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vpcu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.take   = 1'b0;
    cmd.mop    = vpcu_pkg::MOP_NONE;
    unique case (state)
      vpcu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = vpcu_pkg::S_EXEC;
        end
      end
      vpcu_pkg::S_EXEC: begin
        cmd.mop = vpcu_pkg::MOP_EXEC;
        unique case (sts.opcode)
          vpcu_pkg::OPC_BUY:    state_next = vpcu_pkg::S_BUY;
          vpcu_pkg::OPC_CHANGE: state_next = vpcu_pkg::S_DIV10;
          default:              state_next = vpcu_pkg::S_OUT;
        endcase
      end
      vpcu_pkg::S_BUY: begin
        cmd.mop    = vpcu_pkg::MOP_BUY;
        state_next = vpcu_pkg::S_OUT;
      end
      vpcu_pkg::S_DIV10: begin
        cmd.mop    = vpcu_pkg::MOP_DIV10;
        state_next = vpcu_pkg::S_MIN10;
      end
      vpcu_pkg::S_MIN10: begin
        cmd.mop    = vpcu_pkg::MOP_MIN10;
        state_next = vpcu_pkg::S_SUB10;
      end
      vpcu_pkg::S_SUB10: begin
        cmd.mop    = vpcu_pkg::MOP_SUB10;
        state_next = vpcu_pkg::S_DIV5;
      end
      vpcu_pkg::S_DIV5: begin
        cmd.mop    = vpcu_pkg::MOP_DIV5;
        state_next = vpcu_pkg::S_MIN5;
      end
      vpcu_pkg::S_MIN5: begin
        cmd.mop    = vpcu_pkg::MOP_MIN5;
        state_next = vpcu_pkg::S_SUB5;
      end
      vpcu_pkg::S_SUB5: begin
        cmd.mop    = vpcu_pkg::MOP_SUB5;
        state_next = vpcu_pkg::S_ONES;
      end
      vpcu_pkg::S_ONES: begin
        cmd.mop    = vpcu_pkg::MOP_ONES;
        state_next = vpcu_pkg::S_COMMIT;
      end
      vpcu_pkg::S_COMMIT: begin
        cmd.mop    = vpcu_pkg::MOP_COMMIT;
        state_next = vpcu_pkg::S_OUT;
      end
      vpcu_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.mop    = vpcu_pkg::MOP_OUT;
          state_next = vpcu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vpcu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vpcu_dp.sv
// ----------------------------------------------------------------------------
// Vending price and change unit datapath
// Price memory, slot valid bits, coin inventory and change arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vpcu_dp #(
  parameter int PRODUCT_SLOTS = vpcu_pkg::PRODUCT_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire vpcu_pkg::cmd_t                cmd,
  output vpcu_pkg::sts_t                     sts,
  input  wire logic [2:0]                    opcode,
  input  wire logic [vpcu_pkg::CODE_W-1:0]   product_code,
  input  wire logic [vpcu_pkg::MONEY_W-1:0]  new_price,
  input  wire logic [vpcu_pkg::MONEY_W-1:0]  amount,
  input  wire logic [vpcu_pkg::ADD_W-1:0]    add_ones,
  input  wire logic [vpcu_pkg::ADD_W-1:0]    add_fives,
  input  wire logic [vpcu_pkg::ADD_W-1:0]    add_tens,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vpcu_pkg::MONEY_W-1:0]       amount_left,
  output logic [vpcu_pkg::MONEY_W-1:0]       paid_ones,
  output logic [vpcu_pkg::FIVES_W-1:0]       paid_fives,
  output logic [vpcu_pkg::TENS_W-1:0]        paid_tens,
  output logic [1:0]                         status
);

  localparam int ADDR_W = (PRODUCT_SLOTS > 1) ? $clog2(PRODUCT_SLOTS) : 1;
  localparam int PROD_W = 33;
  localparam int RECIP  = 52429;
  localparam int SHIFT10 = 19;
  localparam int SHIFT5  = 18;
  localparam int MW = vpcu_pkg::MONEY_W;

  logic [2:0]                     cur_op;
  logic [vpcu_pkg::CODE_W-1:0]    cur_code;
  logic [MW-1:0]                  cur_price;
  logic [MW-1:0]                  cur_amount;
  logic [vpcu_pkg::ADD_W-1:0]     cur_add_ones;
  logic [vpcu_pkg::ADD_W-1:0]     cur_add_fives;
  logic [vpcu_pkg::ADD_W-1:0]     cur_add_tens;

  logic [PRODUCT_SLOTS-1:0]       slot_valid;
  logic [MW-1:0]                  ones_held;
  logic [MW-1:0]                  fives_held;
  logic [MW-1:0]                  tens_held;

  logic [vpcu_pkg::FIVES_W-1:0]   quo;
  logic [vpcu_pkg::TENS_W-1:0]    take_tens;
  logic [vpcu_pkg::FIVES_W-1:0]   take_fives;
  logic [MW-1:0]                  take_ones;
  logic [MW-1:0]                  rem;

  logic [MW-1:0]                  res_left;
  logic [MW-1:0]                  res_ones;
  logic [vpcu_pkg::FIVES_W-1:0]   res_fives;
  logic [vpcu_pkg::TENS_W-1:0]    res_tens;
  logic [1:0]                     res_status;

  logic [vpcu_pkg::CODE_EXT_W-1:0] code_ext;
  logic [ADDR_W-1:0]              addr;
  logic                           in_range;
  logic                           ram_we;
  logic                           ram_re;
  logic [MW-1:0]                  ram_rdata;
  logic [MW-1:0]                  price;
  logic [PROD_W-1:0]              prod10;
  logic [PROD_W-1:0]              prod5;
  logic [MW:0]                    sum_ones;
  logic [MW:0]                    sum_fives;
  logic [MW:0]                    sum_tens;
  logic [MW-1:0]                  tens_value;
  logic [MW-1:0]                  fives_value;
  logic [MW-1:0]                  ones_min;

  assign code_ext = vpcu_pkg::CODE_EXT_W'(cur_code);
  assign addr     = code_ext[ADDR_W-1:0];
  assign in_range = code_ext < vpcu_pkg::CODE_EXT_W'(PRODUCT_SLOTS);
  assign ram_we   = (cmd.mop == vpcu_pkg::MOP_EXEC) && (cur_op == vpcu_pkg::OPC_WRITE)
                    && in_range;
  assign ram_re   = (cmd.mop == vpcu_pkg::MOP_EXEC) && (cur_op == vpcu_pkg::OPC_BUY);

  vpcu_ram #(
    .WIDTH(MW),
    .DEPTH(PRODUCT_SLOTS)
  ) u_price_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (addr),
    .wdata(cur_price),
    .rdata(ram_rdata)
  );

  assign price = (in_range && slot_valid[addr]) ? ram_rdata : '0;

  assign prod10 = PROD_W'(cur_amount) * PROD_W'(RECIP);
  assign prod5  = PROD_W'(rem) * PROD_W'(RECIP);

  assign sum_ones  = {1'b0, ones_held} + (MW + 1)'(cur_add_ones);
  assign sum_fives = {1'b0, fives_held} + (MW + 1)'(cur_add_fives);
  assign sum_tens  = {1'b0, tens_held} + (MW + 1)'(cur_add_tens);

  assign tens_value  = (MW'(take_tens) << 3) + (MW'(take_tens) << 1);
  assign fives_value = (MW'(take_fives) << 2) + MW'(take_fives);
  assign ones_min    = (rem < ones_held) ? rem : ones_held;

  assign sts.opcode   = cur_op;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      slot_valid <= '0;
      ones_held  <= '0;
      fives_held <= '0;
      tens_held  <= '0;
    end else begin
      if (cmd.mop == vpcu_pkg::MOP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.mop == vpcu_pkg::MOP_EXEC) begin
        case (cur_op)
          vpcu_pkg::OPC_WRITE: begin
            if (in_range) begin
              slot_valid[addr] <= 1'b1;
            end
          end
          vpcu_pkg::OPC_DELETE: begin
            if (in_range) begin
              slot_valid[addr] <= 1'b0;
            end
          end
          vpcu_pkg::OPC_RESTOCK: begin
            ones_held  <= sum_ones[MW] ? '1 : sum_ones[MW-1:0];
            fives_held <= sum_fives[MW] ? '1 : sum_fives[MW-1:0];
            tens_held  <= sum_tens[MW] ? '1 : sum_tens[MW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.mop == vpcu_pkg::MOP_COMMIT && rem == '0) begin
        tens_held  <= tens_held - MW'(take_tens);
        fives_held <= fives_held - MW'(take_fives);
        ones_held  <= ones_held - take_ones;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_op        <= opcode;
      cur_code      <= product_code;
      cur_price     <= new_price;
      cur_amount    <= amount;
      cur_add_ones  <= add_ones;
      cur_add_fives <= add_fives;
      cur_add_tens  <= add_tens;
      res_left      <= '0;
      res_ones      <= '0;
      res_fives     <= '0;
      res_tens      <= '0;
      res_status    <= vpcu_pkg::ST_OK;
    end
    unique case (cmd.mop)
      vpcu_pkg::MOP_BUY: begin
        if (cur_amount >= price) begin
          res_left <= cur_amount - price;
        end else begin
          res_left   <= cur_amount;
          res_status <= vpcu_pkg::ST_CREDIT;
        end
      end
      vpcu_pkg::MOP_DIV10: begin
        quo <= vpcu_pkg::FIVES_W'(prod10 >> SHIFT10);
      end
      vpcu_pkg::MOP_MIN10: begin
        take_tens <= (MW'(quo) < tens_held) ? quo[vpcu_pkg::TENS_W-1:0]
                                            : tens_held[vpcu_pkg::TENS_W-1:0];
      end
      vpcu_pkg::MOP_SUB10: begin
        rem <= cur_amount - tens_value;
      end
      vpcu_pkg::MOP_DIV5: begin
        quo <= vpcu_pkg::FIVES_W'(prod5 >> SHIFT5);
      end
      vpcu_pkg::MOP_MIN5: begin
        take_fives <= (MW'(quo) < fives_held) ? quo : fives_held[vpcu_pkg::FIVES_W-1:0];
      end
      vpcu_pkg::MOP_SUB5: begin
        rem <= rem - fives_value;
      end
      vpcu_pkg::MOP_ONES: begin
        take_ones <= ones_min;
        rem       <= rem - ones_min;
      end
      vpcu_pkg::MOP_COMMIT: begin
        if (rem != '0) begin
          res_left   <= cur_amount;
          res_status <= vpcu_pkg::ST_NO_CHANGE;
        end else begin
          res_tens  <= take_tens;
          res_fives <= take_fives;
          res_ones  <= take_ones;
        end
      end
      vpcu_pkg::MOP_OUT: begin
        amount_left <= res_left;
        paid_ones   <= res_ones;
        paid_fives  <= res_fives;
        paid_tens   <= res_tens;
        status      <= res_status;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vending_price_and_change_unit_top.sv
// ----------------------------------------------------------------------------
// Vending price and change unit
// Price table, coin inventory and greedy change with one result per transaction.
// ----------------------------------------------------------------------------
// The unit handles one transaction at a time and returns exactly one result for
// each. Write, delete, restock and unused opcodes pass through the execute and
// output states, buy adds a state because of the registered read of the price
// memory, and give change runs the tens and fives divide, minimum and subtract
// steps and then the ones step one after another, sharing the quotient and
// remainder registers of the datapath. The next transaction is accepted in the
// cycle after a result is loaded. A finished result sits in the output register
// until it is taken, and a following result waits in the datapath, with the
// controller held in its output state, until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module vending_price_and_change_unit_top #(
  parameter int PRODUCT_SLOTS = vpcu_pkg::PRODUCT_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    opcode,
  input  wire logic [vpcu_pkg::CODE_W-1:0]   product_code,
  input  wire logic [vpcu_pkg::MONEY_W-1:0]  new_price,
  input  wire logic [vpcu_pkg::MONEY_W-1:0]  amount,
  input  wire logic [vpcu_pkg::ADD_W-1:0]    add_ones,
  input  wire logic [vpcu_pkg::ADD_W-1:0]    add_fives,
  input  wire logic [vpcu_pkg::ADD_W-1:0]    add_tens,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vpcu_pkg::MONEY_W-1:0]       amount_left,
  output logic [vpcu_pkg::MONEY_W-1:0]       paid_ones,
  output logic [vpcu_pkg::FIVES_W-1:0]       paid_fives,
  output logic [vpcu_pkg::TENS_W-1:0]        paid_tens,
  output logic [1:0]                         status
);

  vpcu_pkg::cmd_t cmd;
  vpcu_pkg::sts_t sts;

  vpcu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  vpcu_dp #(
    .PRODUCT_SLOTS(PRODUCT_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .product_code(product_code),
    .new_price   (new_price),
    .amount      (amount),
    .add_ones    (add_ones),
    .add_fives   (add_fives),
    .add_tens    (add_tens),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .amount_left (amount_left),
    .paid_ones   (paid_ones),
    .paid_fives  (paid_fives),
    .paid_tens   (paid_tens),
    .status      (status)
  );

endmodule

`default_nettype wire
